### rtl/core/hbib_pkg.sv
// ----------------------------------------------------------------------------
// Hash bucket index builder package
// Shared field widths, bucket geometry, opcode and status codes.
// ----------------------------------------------------------------------------
package hbib_pkg;

    // Bucket geometry: bucket = value mod BUCKETS, taken from the low bits.
    localparam int BUCKETS = 256;
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam logic [BKT_W-1:0] LAST_BUCKET = BKT_W'(BUCKETS - 1);

    // Request and result field widths.
    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;
    localparam int ADDR_W   = 10;
    localparam int ROW_W    = 10;
    localparam int START_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int TOTAL_W  = 11;
    localparam int STATUS_W = 2;

    // Bucket numbers at or above this limit are out of range.
    localparam logic [ADDR_W:0] BUCKET_LIMIT = (ADDR_W + 1)'(BUCKETS);

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 80;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD        = 2'd0,
        OP_BUILD       = 2'd1,
        OP_READ_ENTRY  = 2'd2,
        OP_READ_BUCKET = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_RANGE     = 2'd2,
        STS_NOT_BUILT = 2'd3
    } status_t;

endpackage

### rtl/core/hbib_ram.sv
// ----------------------------------------------------------------------------
// Hash bucket index builder RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hbib_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/hash_bucket_index_builder.sv
// ----------------------------------------------------------------------------
// Hash bucket index builder
// Build-side index of a hash join: load, bucket sort by value mod BUCKETS, read.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel, one result per request leaves on
// m_axis. A load appends a value; its load position becomes its row number.
// A build counts values per bucket, forms the bucket start offsets and then
// scatters (value, row) pairs into a bucket-ordered store, keeping load order
// inside each bucket. Reads return one sorted entry or one bucket's start,
// count and empty flag. The first load after a build starts a new set.
// Loads and reads take one request per cycle while no build runs and the
// result path is not stalled. The RAM read and the read stage both register
// at the accepting edge, and the output register takes the result from the
// read stage, so m_axis_tvalid rises once the read stage moves on. A build
// holds s_axis_tready low while it clears the counts bucket by bucket, runs
// the histogram read-modify-write per value, forms the prefix sum per bucket,
// scatters each value and then posts the build's own result.
// Reset clears the value count, the built flag and both pipeline stages; the
// RAM contents are not cleared. When the receiver stalls, the result holds in
// the output register, one more result waits in the read stage, and after
// that s_axis_tready drops until the output drains.
// ----------------------------------------------------------------------------
module hash_bucket_index_builder #(
    parameter int CAPACITY = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Request channel.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: value [31:0], address [41:32], zero [47:42]
    input  logic [hbib_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: opcode [1:0]
    input  logic [hbib_pkg::OPCODE_W-1:0]  s_axis_tuser,
    // Result channel.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: value_res [31:0], row_index [41:32], bucket_start [51:42],
    //        bucket_count [62:52], bucket_empty [63], total [74:64], zero [79:75]
    output logic [hbib_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser: status [1:0]
    output logic [hbib_pkg::STATUS_W-1:0]  m_axis_tuser
);

    // Index width of the value stores and width of a count up to CAPACITY.
    localparam int CAP_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > hbib_pkg::ADDR_W) ? CNT_W : hbib_pkg::ADDR_W;
    localparam int SORT_W = hbib_pkg::VALUE_W + CAP_W;
    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_HIST_RD,
        ST_HIST_KEY,
        ST_HIST_WR,
        ST_PREFIX_RD,
        ST_PREFIX_WR,
        ST_SCAT_RD,
        ST_SCAT_KEY,
        ST_SCAT_WR,
        ST_DONE
    } state_t;

    // What the read stage has to pick up from the RAM outputs.
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_ENTRY,
        KIND_BUCKET
    } kind_t;

    // Request fields.
    hbib_pkg::opcode_t                in_op;
    logic [hbib_pkg::VALUE_W-1:0]     in_value;
    logic [hbib_pkg::ADDR_W-1:0]      in_address;
    logic                             in_accept;

    // Control state.
    state_t                           state_reg, state_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic                             built_reg, built_next;
    logic [CNT_W-1:0]                 idx_reg, idx_next;
    logic [hbib_pkg::BKT_W-1:0]       bkt_reg, bkt_next;
    logic [CNT_W-1:0]                 run_reg, run_next;
    logic                             p1_valid_reg, p1_valid_next;
    logic                             m_valid_reg, m_valid_next;

    // Read stage and output payload.
    hbib_pkg::status_t                p1_status_reg, p1_status_next;
    kind_t                            p1_kind_reg, p1_kind_next;
    logic [CNT_W-1:0]                 p1_total_reg, p1_total_next;
    hbib_pkg::status_t                m_status_reg, m_status_next;
    logic [hbib_pkg::VALUE_W-1:0]     m_value_reg, m_value_next;
    logic [hbib_pkg::ROW_W-1:0]       m_row_reg, m_row_next;
    logic [hbib_pkg::START_W-1:0]     m_start_reg, m_start_next;
    logic [hbib_pkg::COUNT_W-1:0]     m_count_reg, m_count_next;
    logic                             m_empty_reg, m_empty_next;
    logic [hbib_pkg::TOTAL_W-1:0]     m_total_reg, m_total_next;

    // Handshake and decode helpers.
    logic                             p1_move;
    logic [CNT_W-1:0]                 eff_count;
    logic                             store_full;
    logic [CNT_W-1:0]                 idx_inc;
    logic [CMP_W-1:0]                 addr_cmp;
    logic [CMP_W-1:0]                 count_cmp;
    logic [hbib_pkg::BKT_W-1:0]       key;

    // RAM ports.
    logic                             ld_we, ld_re;
    logic [CAP_W-1:0]                 ld_waddr, ld_raddr;
    logic [hbib_pkg::VALUE_W-1:0]     ld_rdata;
    logic                             so_we, so_re;
    logic [CAP_W-1:0]                 so_waddr, so_raddr;
    logic [SORT_W-1:0]                so_wdata, so_rdata;
    logic                             bc_we, bc_re;
    logic [hbib_pkg::BKT_W-1:0]       bc_waddr, bc_raddr;
    logic [CNT_W-1:0]                 bc_wdata, bc_rdata;
    logic                             bs_we, bs_re;
    logic [CAP_W-1:0]                 bs_rdata;
    logic                             cu_we;
    logic [hbib_pkg::BKT_W-1:0]       cu_waddr;
    logic [CAP_W-1:0]                 cu_wdata, cu_rdata;

    assign in_op      = hbib_pkg::opcode_t'(s_axis_tuser);
    assign in_value   = s_axis_tdata[31:0];
    assign in_address = s_axis_tdata[41:32];

    // The read stage may move on when the output register is free or emptying.
    assign p1_move       = p1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = (state_reg == ST_IDLE) && (!p1_valid_reg || p1_move);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // A load after a build restarts the set from position zero.
    assign eff_count  = built_reg ? '0 : count_reg;
    assign store_full = (eff_count == CAP_COUNT);
    assign idx_inc    = idx_reg + 1'b1;
    assign addr_cmp   = CMP_W'(in_address);
    assign count_cmp  = CMP_W'(count_reg);
    // Bucket of the value currently held at the loaded-store read port.
    assign key        = ld_rdata[hbib_pkg::BKT_W-1:0];

    // Loaded values: written by loads, walked twice by a build.
    assign ld_we    = in_accept && (in_op == hbib_pkg::OP_LOAD) && !store_full;
    assign ld_waddr = eff_count[CAP_W-1:0];
    assign ld_re    = (state_reg == ST_HIST_RD) || (state_reg == ST_SCAT_RD);
    assign ld_raddr = idx_reg[CAP_W-1:0];

    // Sorted store: value above row.
    assign so_we    = (state_reg == ST_SCAT_WR);
    assign so_waddr = cu_rdata;
    assign so_wdata = {ld_rdata, idx_reg[CAP_W-1:0]};
    assign so_re    = in_accept && (in_op == hbib_pkg::OP_READ_ENTRY);
    assign so_raddr = CAP_W'(in_address);

    // Bucket starts and the fill cursors both take the running prefix sum.
    assign bs_we    = (state_reg == ST_PREFIX_WR);
    assign bs_re    = in_accept && (in_op == hbib_pkg::OP_READ_BUCKET);
    assign cu_we    = (state_reg == ST_PREFIX_WR) || (state_reg == ST_SCAT_WR);
    assign cu_waddr = (state_reg == ST_SCAT_WR) ? key : bkt_reg;
    assign cu_wdata = (state_reg == ST_SCAT_WR) ? cu_rdata + 1'b1 : run_reg[CAP_W-1:0];

    // Bucket counts: cleared, incremented and read back in turn.
    always_comb begin
        bc_we    = 1'b0;
        bc_waddr = bkt_reg;
        bc_wdata = '0;
        bc_re    = 1'b0;
        bc_raddr = bkt_reg;
        if (state_reg == ST_HIST_WR) begin
            bc_we    = 1'b1;
            bc_waddr = key;
            bc_wdata = bc_rdata + 1'b1;
        end else if (state_reg == ST_CLEAR) begin
            bc_we = 1'b1;
        end
        if (state_reg == ST_HIST_KEY) begin
            bc_re    = 1'b1;
            bc_raddr = key;
        end else if (state_reg == ST_PREFIX_RD) begin
            bc_re = 1'b1;
        end else if (bs_re) begin
            bc_re    = 1'b1;
            bc_raddr = in_address[hbib_pkg::BKT_W-1:0];
        end
    end

    // Build sequencer.
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        bkt_next   = bkt_reg;
        run_next   = run_reg;
        built_next = built_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    priority if (in_op == hbib_pkg::OP_BUILD) begin
                        state_next = ST_CLEAR;
                        bkt_next   = '0;
                    end else if (in_op == hbib_pkg::OP_LOAD) begin
                        built_next = 1'b0;
                        count_next = store_full ? eff_count : eff_count + 1'b1;
                    end else begin
                        built_next = built_reg;
                    end
                end
            end
            ST_CLEAR: begin
                bkt_next = bkt_reg + 1'b1;
                idx_next = '0;
                run_next = '0;
                if (bkt_reg == hbib_pkg::LAST_BUCKET) begin
                    state_next = (count_reg == '0) ? ST_PREFIX_RD : ST_HIST_RD;
                end
            end
            ST_HIST_RD:  state_next = ST_HIST_KEY;
            ST_HIST_KEY: state_next = ST_HIST_WR;
            ST_HIST_WR: begin
                idx_next   = idx_inc;
                state_next = (idx_inc == count_reg) ? ST_PREFIX_RD : ST_HIST_RD;
            end
            ST_PREFIX_RD: state_next = ST_PREFIX_WR;
            ST_PREFIX_WR: begin
                run_next = run_reg + bc_rdata;
                bkt_next = bkt_reg + 1'b1;
                idx_next = '0;
                if (bkt_reg == hbib_pkg::LAST_BUCKET) begin
                    state_next = (count_reg == '0) ? ST_DONE : ST_SCAT_RD;
                end else begin
                    state_next = ST_PREFIX_RD;
                end
            end
            ST_SCAT_RD:  state_next = ST_SCAT_KEY;
            ST_SCAT_KEY: state_next = ST_SCAT_WR;
            ST_SCAT_WR: begin
                idx_next   = idx_inc;
                state_next = (idx_inc == count_reg) ? ST_DONE : ST_SCAT_RD;
            end
            ST_DONE: begin
                built_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Read stage: status is settled at acceptance; the RAM read data registers at the same edge.
    always_comb begin
        p1_valid_next  = p1_valid_reg && !p1_move;
        p1_status_next = p1_status_reg;
        p1_kind_next   = p1_kind_reg;
        p1_total_next  = p1_total_reg;
        if (in_accept && (in_op != hbib_pkg::OP_BUILD)) begin
            p1_valid_next = 1'b1;
            p1_total_next = count_reg;
            p1_kind_next  = KIND_NONE;
            unique case (in_op)
                hbib_pkg::OP_LOAD: begin
                    p1_status_next = store_full ? hbib_pkg::STS_FULL : hbib_pkg::STS_OK;
                    p1_total_next  = store_full ? eff_count : eff_count + 1'b1;
                end
                hbib_pkg::OP_READ_ENTRY: begin
                    priority if (!built_reg) begin
                        p1_status_next = hbib_pkg::STS_NOT_BUILT;
                    end else if (addr_cmp >= count_cmp) begin
                        p1_status_next = hbib_pkg::STS_RANGE;
                    end else begin
                        p1_status_next = hbib_pkg::STS_OK;
                        p1_kind_next   = KIND_ENTRY;
                    end
                end
                hbib_pkg::OP_READ_BUCKET: begin
                    priority if (!built_reg) begin
                        p1_status_next = hbib_pkg::STS_NOT_BUILT;
                    end else if ({1'b0, in_address} >= hbib_pkg::BUCKET_LIMIT) begin
                        p1_status_next = hbib_pkg::STS_RANGE;
                    end else begin
                        p1_status_next = hbib_pkg::STS_OK;
                        p1_kind_next   = KIND_BUCKET;
                    end
                end
                default: p1_status_next = hbib_pkg::STS_OK;
            endcase
        end else if (state_reg == ST_DONE) begin
            // The build's own result; the read stage is always empty here.
            p1_valid_next  = 1'b1;
            p1_status_next = hbib_pkg::STS_OK;
            p1_kind_next   = KIND_NONE;
            p1_total_next  = count_reg;
        end
    end

    // Output register.
    always_comb begin
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_row_next    = m_row_reg;
        m_start_next  = m_start_reg;
        m_count_next  = m_count_reg;
        m_empty_next  = m_empty_reg;
        m_total_next  = m_total_reg;
        if (p1_move) begin
            m_valid_next  = 1'b1;
            m_status_next = p1_status_reg;
            m_total_next  = hbib_pkg::TOTAL_W'(p1_total_reg);
            m_value_next  = '0;
            m_row_next    = '0;
            m_start_next  = '0;
            m_count_next  = '0;
            m_empty_next  = 1'b0;
            if (p1_kind_reg == KIND_ENTRY) begin
                m_value_next = so_rdata[SORT_W-1:CAP_W];
                m_row_next   = hbib_pkg::ROW_W'(so_rdata[CAP_W-1:0]);
            end else if (p1_kind_reg == KIND_BUCKET) begin
                m_count_next = hbib_pkg::COUNT_W'(bc_rdata);
                // An empty bucket reports start zero instead of a start offset.
                if (bc_rdata == '0) begin
                    m_empty_next = 1'b1;
                end else begin
                    m_start_next = hbib_pkg::START_W'(bs_rdata);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            built_reg    <= 1'b0;
            idx_reg      <= '0;
            bkt_reg      <= '0;
            run_reg      <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            built_reg    <= built_next;
            idx_reg      <= idx_next;
            bkt_reg      <= bkt_next;
            run_reg      <= run_next;
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        p1_status_reg <= p1_status_next;
        p1_kind_reg   <= p1_kind_next;
        p1_total_reg  <= p1_total_next;
        m_status_reg  <= m_status_next;
        m_value_reg   <= m_value_next;
        m_row_reg     <= m_row_next;
        m_start_reg   <= m_start_next;
        m_count_reg   <= m_count_next;
        m_empty_reg   <= m_empty_next;
        m_total_reg   <= m_total_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {5'd0, m_total_reg, m_empty_reg, m_count_reg,
                            m_start_reg, m_row_reg, m_value_reg};

    hbib_ram #(.DEPTH(CAPACITY), .WIDTH(hbib_pkg::VALUE_W)) u_loaded (
        .aclk    (aclk),
        .wr_en   (ld_we),
        .wr_addr (ld_waddr),
        .wr_data (in_value),
        .rd_en   (ld_re),
        .rd_addr (ld_raddr),
        .rd_data (ld_rdata)
    );

    hbib_ram #(.DEPTH(CAPACITY), .WIDTH(SORT_W)) u_sorted (
        .aclk    (aclk),
        .wr_en   (so_we),
        .wr_addr (so_waddr),
        .wr_data (so_wdata),
        .rd_en   (so_re),
        .rd_addr (so_raddr),
        .rd_data (so_rdata)
    );

    hbib_ram #(.DEPTH(hbib_pkg::BUCKETS), .WIDTH(CNT_W)) u_counts (
        .aclk    (aclk),
        .wr_en   (bc_we),
        .wr_addr (bc_waddr),
        .wr_data (bc_wdata),
        .rd_en   (bc_re),
        .rd_addr (bc_raddr),
        .rd_data (bc_rdata)
    );

    hbib_ram #(.DEPTH(hbib_pkg::BUCKETS), .WIDTH(CAP_W)) u_starts (
        .aclk    (aclk),
        .wr_en   (bs_we),
        .wr_addr (bkt_reg),
        .wr_data (run_reg[CAP_W-1:0]),
        .rd_en   (bs_re),
        .rd_addr (in_address[hbib_pkg::BKT_W-1:0]),
        .rd_data (bs_rdata)
    );

    hbib_ram #(.DEPTH(hbib_pkg::BUCKETS), .WIDTH(CAP_W)) u_cursor (
        .aclk    (aclk),
        .wr_en   (cu_we),
        .wr_addr (cu_waddr),
        .wr_data (cu_wdata),
        .rd_en   (state_reg == ST_SCAT_KEY),
        .rd_addr (key),
        .rd_data (cu_rdata)
    );

endmodule

### rtl/core/hbib_checker.sv
// ----------------------------------------------------------------------------
// Hash bucket index builder checker
// Port-level assertions on both channels, bound to the top level.
// ----------------------------------------------------------------------------
module hbib_checker #(
    parameter int CAPACITY = 1024
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [hbib_pkg::OPCODE_W-1:0]  s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [hbib_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [hbib_pkg::STATUS_W-1:0]  m_axis_tuser
);

    localparam logic [hbib_pkg::TOTAL_W-1:0] FULL_TOTAL = hbib_pkg::TOTAL_W'(CAPACITY);

    logic [hbib_pkg::VALUE_W-1:0] res_value;
    logic [hbib_pkg::ROW_W-1:0]   res_row;
    logic [hbib_pkg::START_W-1:0] res_start;
    logic [hbib_pkg::COUNT_W-1:0] res_count;
    logic                         res_empty;
    logic [hbib_pkg::TOTAL_W-1:0] res_total;

    assign res_value = m_axis_tdata[31:0];
    assign res_row   = m_axis_tdata[41:32];
    assign res_start = m_axis_tdata[51:42];
    assign res_count = m_axis_tdata[62:52];
    assign res_empty = m_axis_tdata[63];
    assign res_total = m_axis_tdata[74:64];

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Reset empties the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A dropped load only happens with the store holding CAPACITY values.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == hbib_pkg::STS_FULL) |-> res_total == FULL_TOTAL)
        else $error("store full reported below capacity");

    // Failed requests and empty buckets carry zero payload fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser != hbib_pkg::STS_OK || res_empty) |->
            res_value == '0 && res_row == '0 && res_start == '0 && res_count == '0)
        else $error("nonzero payload on failed request or empty bucket");

    // The request channel is closed right after a build request is accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == hbib_pkg::OP_BUILD) |=>
            !s_axis_tready)
        else $error("request channel open right after a build request");

endmodule

bind hash_bucket_index_builder hbib_checker #(.CAPACITY(CAPACITY)) u_hbib_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
